// ----- rtl/core/dspv_pkg.sv -----
// Shared types, constants and helpers for the date string parse and validate unit.
// Used by dspv_capture, dspv_decode and date_string_parse_validate_unit.
package dspv_pkg;

    localparam int unsigned DateLen  = 10;
    localparam int unsigned CountSat = 11;
    localparam int unsigned StoreLen = DateLen - 1;
    localparam int unsigned CntW     = $clog2(CountSat + 1);
    localparam int unsigned IdxW     = $clog2(StoreLen);

    localparam logic [7:0] ChDot   = 8'h2e;
    localparam logic [7:0] ChDash  = 8'h2d;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;

    localparam logic [6:0] MaxMonth   = 7'd12;
    localparam logic [6:0] MaxDay     = 7'd31;
    localparam logic [6:0] MaxDayShrt = 7'd30;
    localparam logic [6:0] MaxDayFeb  = 7'd29;

    localparam logic [6:0] MonFeb = 7'd2;
    localparam logic [6:0] MonApr = 7'd4;
    localparam logic [6:0] MonJun = 7'd6;
    localparam logic [6:0] MonSep = 7'd9;
    localparam logic [6:0] MonNov = 7'd11;

    typedef logic [DateLen-1:0][7:0] t_text;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_LEN = 2'd1,
        ST_NO_FORM = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef struct packed {
        logic        found;
        logic        valid_date;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_dec;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= ChZero) && (c <= ChNine);
    endfunction

endpackage

// ----- rtl/core/dspv_capture.sv -----
// Character store, length count and snapshot register for one finished string.
// Depends on dspv_pkg.
module dspv_capture (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_character,
    input  logic                 i_last_char,
    input  logic                 i_advance,
    output logic                 o_stall,
    output logic                 o_snap_valid,
    output logic                 o_len_ok,
    output dspv_pkg::t_text      o_text
);
    import dspv_pkg::*;

    logic [7:0]      r_store [StoreLen];
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic            r_snap_valid;
    logic            r_len_ok;
    t_text           r_text;
    t_text           n_text;
    logic            accept;

    assign o_stall      = r_snap_valid && !i_advance;
    assign accept       = i_valid && !o_stall;
    assign o_snap_valid = r_snap_valid;
    assign o_len_ok     = r_len_ok;
    assign o_text       = r_text;

    always_comb begin
        n_count = (r_count >= CntW'(CountSat)) ? CntW'(CountSat) : r_count + 1'b1;
        for (int i = 0; i < StoreLen; i++) begin
            n_text[i] = r_store[i];
        end
        n_text[DateLen-1] = i_character;
    end

    always_ff @(posedge i_clk) begin
        if (accept && (r_count < CntW'(StoreLen))) begin
            r_store[r_count[IdxW-1:0]] <= i_character;
        end
        if (accept && i_last_char) begin
            r_text   <= n_text;
            r_len_ok <= (r_count == CntW'(DateLen - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_snap_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= i_last_char ? '0 : n_count;
            end
            if (accept && i_last_char) begin
                r_snap_valid <= 1'b1;
            end else if (i_advance) begin
                r_snap_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/core/dspv_decode.sv -----
// Pattern match, digit conversion and calendar check of a ten-character snapshot.
// Depends on dspv_pkg.
module dspv_decode (
    input  dspv_pkg::t_text i_text,
    output dspv_pkg::t_dec  o_dec
);
    import dspv_pkg::*;

    localparam logic [13:0] K1000 = 14'd1000;
    localparam logic [13:0] K100  = 14'd100;
    localparam logic [6:0]  K10   = 7'd10;

    logic       dmy_sep;
    logic       ymd_sep;
    logic       dmy_dig;
    logic       ymd_dig;
    logic       use_dmy;
    logic [3:0] dd_t, dd_o, mm_t, mm_o, y_th, y_hu, y_te, y_on;
    logic [6:0] day, month, y_lo, y_hi;
    logic [13:0] year;
    logic       leap;
    logic       short_mon;

    always_comb begin
        dmy_sep = ((i_text[2] == ChDot) && (i_text[5] == ChDot)) ||
                  ((i_text[2] == ChDash) && (i_text[5] == ChDash));
        ymd_sep = (i_text[4] == ChDot) && (i_text[7] == ChDot);
        dmy_dig = is_dig(i_text[0]) && is_dig(i_text[1]) && is_dig(i_text[3]) &&
                  is_dig(i_text[4]) && is_dig(i_text[6]) && is_dig(i_text[7]) &&
                  is_dig(i_text[8]) && is_dig(i_text[9]);
        ymd_dig = is_dig(i_text[0]) && is_dig(i_text[1]) && is_dig(i_text[2]) &&
                  is_dig(i_text[3]) && is_dig(i_text[5]) && is_dig(i_text[6]) &&
                  is_dig(i_text[8]) && is_dig(i_text[9]);
        use_dmy = dmy_sep && dmy_dig;

        if (use_dmy) begin
            dd_t = i_text[0][3:0];
            dd_o = i_text[1][3:0];
            mm_t = i_text[3][3:0];
            mm_o = i_text[4][3:0];
            y_th = i_text[6][3:0];
            y_hu = i_text[7][3:0];
            y_te = i_text[8][3:0];
            y_on = i_text[9][3:0];
        end else begin
            y_th = i_text[0][3:0];
            y_hu = i_text[1][3:0];
            y_te = i_text[2][3:0];
            y_on = i_text[3][3:0];
            mm_t = i_text[5][3:0];
            mm_o = i_text[6][3:0];
            dd_t = i_text[8][3:0];
            dd_o = i_text[9][3:0];
        end

        day   = 7'(dd_t) * K10 + 7'(dd_o);
        month = 7'(mm_t) * K10 + 7'(mm_o);
        y_hi  = 7'(y_th) * K10 + 7'(y_hu);
        y_lo  = 7'(y_te) * K10 + 7'(y_on);
        year  = 14'(y_th) * K1000 + 14'(y_hu) * K100 + 14'(y_lo);

        leap = (y_lo == 7'd0) ? (y_hi[1:0] == 2'b00) : (y_lo[1:0] == 2'b00);
        short_mon = (month == MonApr) || (month == MonJun) ||
                    (month == MonSep) || (month == MonNov);

        o_dec.found      = use_dmy || (ymd_sep && ymd_dig);
        o_dec.valid_date = !(month > MaxMonth) &&
                           !(day > MaxDay) &&
                           !((day > MaxDayShrt) && short_mon) &&
                           !((month == MonFeb) && (day > MaxDayFeb)) &&
                           !((month == MonFeb) && (day == MaxDayFeb) && !leap);
        o_dec.day   = day[4:0];
        o_dec.month = month[3:0];
        o_dec.year  = year;
    end

endmodule

// ----- rtl/core/date_string_parse_validate_unit.sv -----
// Date string parse and validate unit: top level with result register and stored date.
// Depends on dspv_pkg, dspv_capture and dspv_decode.
//
// Input channel: one ASCII character per transfer (i_character), i_last_char set on
// the final character of a string; transfer when i_valid is high and o_stall low.
// Output channel: one result per string, carrying the stored day, month and year
// after that string and a status code; transfer when o_valid is high and i_stall low.
// Strings may follow one another with no gap; a character is taken every cycle while
// o_stall is low. The result of a string goes through the snapshot register, then
// decode into the result register. Throughput: one character per cycle unless
// o_stall is high; one result per cycle at most.
// While a result waits under i_stall, one further finished string is held in the
// snapshot register; o_stall rises only when both are full.
// Reset clears the stored date to zero, the character count and both valid flags.
// Only strings of exactly ten characters in the forms DD.MM.YYYY, DD-MM-YYYY or
// YYYY.MM.DD update the stored date; a failed calendar check clears it.
module date_string_parse_validate_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_character,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_day_out,
    output logic [3:0]  o_month_out,
    output logic [13:0] o_year_out,
    output logic [1:0]  o_status
);
    import dspv_pkg::*;

    logic        snap_valid;
    logic        len_ok;
    t_text       text;
    t_dec        dec;
    logic        advance;
    logic        r_out_valid;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [13:0] r_year;
    t_status     r_status;

    assign advance = snap_valid && (!r_out_valid || !i_stall);

    dspv_capture u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_character  (i_character),
        .i_last_char  (i_last_char),
        .i_advance    (advance),
        .o_stall      (o_stall),
        .o_snap_valid (snap_valid),
        .o_len_ok     (len_ok),
        .o_text       (text)
    );

    dspv_decode u_decode (
        .i_text (text),
        .o_dec  (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_day       <= '0;
            r_month     <= '0;
            r_year      <= '0;
            r_status    <= ST_OK;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                if (!len_ok) begin
                    r_status <= ST_BAD_LEN;
                end else if (!dec.found) begin
                    r_status <= ST_NO_FORM;
                end else if (dec.valid_date) begin
                    r_day    <= dec.day;
                    r_month  <= dec.month;
                    r_year   <= dec.year;
                    r_status <= ST_OK;
                end else begin
                    r_day    <= '0;
                    r_month  <= '0;
                    r_year   <= '0;
                    r_status <= ST_INVALID;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_day_out   = r_day;
    assign o_month_out = r_month;
    assign o_year_out  = r_year;
    assign o_status    = r_status;

endmodule

// ----- test/date_string_parse_validate_unit_checker.sv -----
// Checker for the date string parse and validate unit: tracks character transfers,
// predicts the stored date and status of each finished string, and compares results.
// Depends on dspv_pkg for the status codes.
`timescale 1ns / 1ps

module date_string_parse_validate_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [7:0]  i_character,
    input  logic        i_last_char,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [4:0]  o_day_out,
    input  logic [3:0]  o_month_out,
    input  logic [13:0] o_year_out,
    input  logic [1:0]  o_status,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);

    import dspv_pkg::*;

    localparam logic [7:0] SepDot   = ".";
    localparam logic [7:0] SepDash  = "-";
    localparam logic [7:0] AsciiZero = "0";
    localparam logic [7:0] AsciiNine = "9";
    localparam logic [9:0] DmyDigitMask = 10'b1111011011;
    localparam logic [9:0] YmdDigitMask = 10'b1101101111;

    typedef struct {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        t_status     status;
    } t_date_result;

    logic [7:0]   text_mem [0:9];
    int           chars_in_string;
    logic [4:0]   kept_day;
    logic [3:0]   kept_month;
    logic [13:0]  kept_year;
    t_date_result awaited_q [$];

    function automatic bit digits_present(input logic [9:0] mask);
        bit ok;
        ok = 1'b1;
        for (int i = 0; i < 10; i++) begin
            if (mask[i] && !(text_mem[i] >= AsciiZero && text_mem[i] <= AsciiNine)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic int digit_value(input int pos);
        return int'(text_mem[pos]) - int'(AsciiZero);
    endfunction

    function automatic bit calendar_valid(input int d, input int m, input int y);
        bit leap;
        leap = (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
        if (m > 12 || d > 31) return 1'b0;
        if (d > 30 && (m == 4 || m == 6 || m == 9 || m == 11)) return 1'b0;
        if (m == 2 && d > 29) return 1'b0;
        if (m == 2 && d == 29 && !leap) return 1'b0;
        return 1'b1;
    endfunction

    task automatic absorb_char(input logic [7:0] ch, input logic fin);
        int           len;
        int           d;
        int           m;
        int           y;
        bit           dmy_form;
        bit           ymd_form;
        t_date_result r;
        if (chars_in_string < 10) begin
            text_mem[chars_in_string] = ch;
        end
        len = (chars_in_string + 1 > 11) ? 11 : chars_in_string + 1;
        if (!fin) begin
            chars_in_string = len;
        end else begin
            chars_in_string = 0;
            if (len != 10) begin
                r.status = ST_BAD_LEN;
            end else begin
                dmy_form = ((text_mem[2] == SepDot && text_mem[5] == SepDot) ||
                            (text_mem[2] == SepDash && text_mem[5] == SepDash)) &&
                           digits_present(DmyDigitMask);
                ymd_form = text_mem[4] == SepDot && text_mem[7] == SepDot &&
                           digits_present(YmdDigitMask);
                if (dmy_form) begin
                    d = digit_value(0) * 10 + digit_value(1);
                    m = digit_value(3) * 10 + digit_value(4);
                    y = digit_value(6) * 1000 + digit_value(7) * 100 +
                        digit_value(8) * 10 + digit_value(9);
                end else begin
                    y = digit_value(0) * 1000 + digit_value(1) * 100 +
                        digit_value(2) * 10 + digit_value(3);
                    m = digit_value(5) * 10 + digit_value(6);
                    d = digit_value(8) * 10 + digit_value(9);
                end
                if (!dmy_form && !ymd_form) begin
                    r.status = ST_NO_FORM;
                end else if (calendar_valid(d, m, y)) begin
                    kept_day   = d[4:0];
                    kept_month = m[3:0];
                    kept_year  = y[13:0];
                    r.status   = ST_OK;
                end else begin
                    kept_day   = '0;
                    kept_month = '0;
                    kept_year  = '0;
                    r.status   = ST_INVALID;
                end
            end
            r.day   = kept_day;
            r.month = kept_month;
            r.year  = kept_year;
            awaited_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_date_result r;
        if (!i_rst_n) begin
            awaited_q.delete();
            chars_in_string = 0;
            kept_day        = '0;
            kept_month      = '0;
            kept_year       = '0;
        end else begin
            if (i_valid && !o_stall) begin
                absorb_char(i_character, i_last_char);
            end
            if (o_valid && !i_stall) begin
                o_result_count = o_result_count + 1;
                if (awaited_q.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    $display("%0t: unexpected result day %0d month %0d year %0d status %0d",
                             $time, o_day_out, o_month_out, o_year_out, o_status);
                end else begin
                    r = awaited_q.pop_front();
                    if (o_day_out !== r.day || o_month_out !== r.month ||
                        o_year_out !== r.year || o_status !== r.status) begin
                        o_fail_count = o_fail_count + 1;
                        $display("%0t: mismatch expected day %0d month %0d year %0d status %0d",
                                 $time, r.day, r.month, r.year, r.status);
                        $display("%0t:          actual   day %0d month %0d year %0d status %0d",
                                 $time, o_day_out, o_month_out, o_year_out, o_status);
                    end
                end
            end
        end
        o_pending = awaited_q.size();
    end

endmodule

// ----- test/date_string_parse_validate_unit_test.sv -----
// Testbench top for the date string parse and validate unit: directed and random
// date strings under several idle and stall mixes, verdict from the checker.
// Depends on date_string_parse_validate_unit and date_string_parse_validate_unit_checker.
`timescale 1ns / 1ps

module date_string_parse_validate_unit_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_character;
    logic        i_last_char;
    logic        o_valid;
    logic        i_stall;
    logic [4:0]  o_day_out;
    logic [3:0]  o_month_out;
    logic [13:0] o_year_out;
    logic [1:0]  o_status;

    int fail_count;
    int pending;
    int result_count;
    int idle_pct;
    int stall_pct;
    int chars_sent;
    int strings_sent;

    date_string_parse_validate_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_character (i_character),
        .i_last_char (i_last_char),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_day_out   (o_day_out),
        .o_month_out (o_month_out),
        .o_year_out  (o_year_out),
        .o_status    (o_status)
    );

    date_string_parse_validate_unit_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_character    (i_character),
        .i_last_char    (i_last_char),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_day_out      (o_day_out),
        .o_month_out    (o_month_out),
        .o_year_out     (o_year_out),
        .o_status       (o_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(negedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_char(input logic [7:0] ch, input logic fin);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid     <= 1'b0;
            i_character <= 8'($urandom_range(0, 255));
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_character <= ch;
        i_last_char <= fin;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        chars_sent = chars_sent + 1;
        if (fin) begin
            strings_sent = strings_sent + 1;
        end
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input logic [7:0] text_q [$]);
        for (int i = 0; i < text_q.size(); i++) begin
            send_char(text_q[i], i == text_q.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        logic [7:0] text_q [$];
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
        send_bytes(text_q);
    endtask

    task automatic send_random_string();
        logic [7:0] text_q [$];
        string      s;
        int         kind;
        int         d;
        int         m;
        int         y;
        int         pos;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       d = $urandom_range(0, 99);
            1:       d = 28 + $urandom_range(0, 3);
            default: d = $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 9))
            0:       m = $urandom_range(0, 99);
            1, 2:    m = 2;
            default: m = $urandom_range(0, 12);
        endcase
        case ($urandom_range(0, 9))
            0:       y = 400 * $urandom_range(0, 24);
            1:       y = 100 * $urandom_range(0, 99);
            2:       y = 4 * $urandom_range(0, 2499);
            default: y = $urandom_range(0, 9999);
        endcase
        case ($urandom_range(0, 2))
            0:       s = $sformatf("%02d.%02d.%04d", d, m, y);
            1:       s = $sformatf("%02d-%02d-%04d", d, m, y);
            default: s = $sformatf("%04d.%02d.%02d", y, m, d);
        endcase
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
        if (kind >= 60 && kind < 75) begin
            pos = $urandom_range(0, 9);
            case ($urandom_range(0, 2))
                0:       text_q[pos] = 8'($urandom_range(0, 255));
                1:       text_q[pos] = ".";
                default: text_q[pos] = "-";
            endcase
        end else if (kind >= 75 && kind < 90) begin
            text_q.delete();
            repeat ($urandom_range(1, 14)) begin
                case ($urandom_range(0, 3))
                    0:       text_q.push_back(8'($urandom_range(0, 255)));
                    1:       text_q.push_back($urandom_range(0, 1) ? "." : "-");
                    default: text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
                endcase
            end
        end else if (kind >= 90) begin
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(1, 3)) begin
                    void'(text_q.pop_back());
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
                end
            end
        end
        send_bytes(text_q);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (6) @(negedge i_clk);
    endtask

    initial begin
        int idle_set [4];
        int stall_set [4];
        int target;
        idle_set     = '{0, 49, 0, 16};
        stall_set    = '{0, 0, 49, 16};
        idle_pct     = 0;
        stall_pct    = 0;
        chars_sent   = 0;
        strings_sent = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_character  = '0;
        i_last_char  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_text("25.12.2023");
        send_text("01-01-0000");
        send_text("2024.02.29");
        send_text("29.02.1900");
        send_text("29.02.2000");
        send_text("31.04.2021");
        send_text("00.00.9999");
        send_text("31.12.9999");
        send_text("2023.11.31");
        send_text("32.01.2020");
        send_text("15.13.2020");
        send_text("0000.00.00");
        send_text("12.05-2020");
        send_text("1999-12-31");
        send_text("2a.01.2020");
        send_text("5.1.2020");
        send_text("25.12.20233");
        send_text("25.12.2023extra");
        send_text("A");
        send_text("30.02.2020");
        send_text("99.99.9999");
        drain();

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            target    = chars_sent + 375;
            while (chars_sent < target) begin
                send_random_string();
            end
            drain();
        end
        stall_pct = 0;
        repeat (10) @(negedge i_clk);

        $display("Summary: %0d characters in %0d strings, %0d results checked",
                 chars_sent, strings_sent, result_count);
        $display("Phases: free flow, sender gaps, receiver stalls, and both together");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
